@@ hw/rtl/sll_pkg.sv @@
// Shared constants and types of the sorted linked-list engine.
package sll_pkg;

  // Number of slots in the list storage.
  localparam int unsigned CAPACITY = 256;
  // Bits of a slot index, and of a link that can also hold the nil marker.
  localparam int unsigned SLOT_W   = $clog2(CAPACITY);
  localparam int unsigned PTR_W    = SLOT_W + 1;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  // The link value that marks the end of the list.
  localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(CAPACITY);

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Write controls from the sequencer to the storage.
  typedef struct packed {
    logic               val_we;
    logic [SLOT_W-1:0]  val_addr;
    logic [VALUE_W-1:0] val_data;
    logic               nxt_we;
    logic [SLOT_W-1:0]  nxt_addr;
    logic [PTR_W-1:0]   nxt_data;
  } sll_wr_t;

endpackage

@@ hw/rtl/sll_store.sv @@
// Value and link storage of the linked list, one registered read port.
module sll_store
  import sll_pkg::*;
(
  input  logic               clk_i,
  input  logic [SLOT_W-1:0]  rd_addr_i,
  output logic [VALUE_W-1:0] rd_val_o,
  output logic [PTR_W-1:0]   rd_nxt_o,
  input  sll_wr_t            wr_i
);

  logic [VALUE_W-1:0] val_mem [CAPACITY];
  logic [PTR_W-1:0]   nxt_mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (wr_i.val_we) begin
      val_mem[wr_i.val_addr] <= wr_i.val_data;
    end
    rd_val_o <= val_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.nxt_we) begin
      nxt_mem[wr_i.nxt_addr] <= wr_i.nxt_data;
    end
    rd_nxt_o <= nxt_mem[rd_addr_i];
  end

endmodule

@@ hw/rtl/sorted_linked_list_engine.sv @@
// Top level of the sorted linked-list engine: sequencer, list walk and result register.
//
// The engine keeps an ascending singly linked list of signed 32-bit keys in two
// 256-entry memories, one for values and one for links, plus a head pointer and
// a fill count. An insert transfer stores the key in the next free slot and links
// it in front of the first entry that is greater than or equal to it; when all
// slots are in use it returns status full and changes nothing. A search transfer
// returns the slot and value of the first entry not smaller than the key, or
// status not found. Slots are never freed. One item is worked on at a time and
// the input is stalled meanwhile. The walk visits one slot per clock through the
// single read port of the storage, whose registered link output directly feeds
// the next read address. An insert that links behind an existing entry passes
// through the extra link state to rewrite that entry's link. A finished result
// sits in the output register and the next item can be taken while it waits.
// There is no clearing pass after reset: only data read from linked slots is
// ever used, and those slots have all been written.
module sorted_linked_list_engine
  import sll_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      operation_i,
  input  logic signed [VALUE_W-1:0] key_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [STATUS_W-1:0]       status_o,
  output logic [SLOT_W-1:0]         slot_o,
  output logic signed [VALUE_W-1:0] found_value_o
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WALK   = 3'd1;
  localparam logic [2:0] ST_FINISH = 3'd2;
  localparam logic [2:0] ST_LINK   = 3'd3;
  localparam logic [2:0] ST_RESP   = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [PTR_W-1:0]   fill_q, fill_d;
  logic [PTR_W-1:0]   cur_q, cur_d;
  logic [PTR_W-1:0]   prev_q, prev_d;
  logic               op_q, op_d;
  logic               full_q, full_d;
  logic [VALUE_W-1:0] key_q, key_d;
  logic [VALUE_W-1:0] found_q, found_d;

  logic               out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [VALUE_W-1:0] value_q, value_d;

  logic [SLOT_W-1:0]  rd_addr;
  logic [VALUE_W-1:0] rd_val;
  logic [PTR_W-1:0]   rd_nxt;
  sll_wr_t            wr;

  logic in_xfer;
  logic out_free;
  logic key_above;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // The one shared comparator of the walk: is the key still above the visited entry?
  assign key_above = $signed(key_q) > $signed(rd_val);

  // While idle the head entry is read ahead, so the first compare can follow the
  // accepting edge; during the walk the link just read names the next slot.
  assign rd_addr = (state_q == ST_IDLE) ? head_q[SLOT_W-1:0] : rd_nxt[SLOT_W-1:0];

  sll_store u_store (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .rd_val_o  (rd_val),
    .rd_nxt_o  (rd_nxt),
    .wr_i      (wr)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    fill_d      = fill_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    op_d        = op_q;
    full_d      = full_q;
    key_d       = key_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    slot_d      = slot_q;
    value_d     = value_q;

    wr          = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          op_d   = operation_i;
          key_d  = key_i;
          prev_d = NIL_PTR;
          cur_d  = head_q;
          full_d = (operation_i == OP_INSERT) && (fill_q >= NIL_PTR);
          if ((operation_i == OP_INSERT) && (fill_q >= NIL_PTR)) begin
            state_d = ST_RESP;
          end else if (head_q == NIL_PTR) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        if (key_above) begin
          prev_d = cur_q;
          cur_d  = rd_nxt;
          if (rd_nxt >= NIL_PTR) begin
            cur_d   = NIL_PTR;
            state_d = ST_FINISH;
          end
        end else begin
          found_d = rd_val;
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (op_q == OP_INSERT) begin
          // New slot takes the key and points at the first entry not below it.
          wr.val_we   = 1'b1;
          wr.val_addr = fill_q[SLOT_W-1:0];
          wr.val_data = key_q;
          wr.nxt_we   = 1'b1;
          wr.nxt_addr = fill_q[SLOT_W-1:0];
          wr.nxt_data = cur_q;
          if (prev_q == NIL_PTR) begin
            head_d  = fill_q;
            state_d = ST_RESP;
          end else begin
            state_d = ST_LINK;
          end
        end else begin
          state_d = ST_RESP;
        end
      end

      ST_LINK: begin
        // Hook the new slot in behind the last entry that was smaller.
        wr.nxt_we   = 1'b1;
        wr.nxt_addr = prev_q[SLOT_W-1:0];
        wr.nxt_data = fill_q;
        state_d     = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (op_q == OP_INSERT) begin
            value_d = key_q;
            if (full_q) begin
              status_d = STATUS_FULL;
              slot_d   = '0;
            end else begin
              status_d = STATUS_OK;
              slot_d   = fill_q[SLOT_W-1:0];
              fill_d   = fill_q + PTR_W'(1);
            end
          end else if (cur_q == NIL_PTR) begin
            status_d = STATUS_NOT_FOUND;
            slot_d   = '0;
            value_d  = '0;
          end else begin
            status_d = STATUS_OK;
            slot_d   = cur_q[SLOT_W-1:0];
            value_d  = found_q;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= NIL_PTR;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    op_q     <= op_d;
    full_q   <= full_d;
    key_q    <= key_d;
    found_q  <= found_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    value_q  <= value_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign slot_o        = slot_q;
  assign found_value_o = $signed(value_q);

`ifndef SYNTH
  // The fill count never runs past the number of slots.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= NIL_PTR)
    else $error("fill count exceeds capacity");

  // Between items the list is empty exactly when no slot has been handed out.
  // During the first insert the head moves in the finish state, before the fill count moves in the response state.
  a_head_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ((fill_q == '0) == (head_q == NIL_PTR)))
    else $error("head pointer and fill count disagree");

  // An accepted item keeps the input stalled until its work is done.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input taken again before the item finished");
`endif

endmodule
